// File: hdl/dhfe_pkg.sv
package dhfe_pkg;

    // Header bytes open a frame, footer bytes close it.
    localparam logic [7:0] HDR_BASE  = 8'h5B;
    localparam logic [7:0] HDR_LAST  = 8'h5D;
    localparam logic [7:0] FTR_BASE  = 8'h2B;

    // Frame layout: two header bytes, six payload bytes, one footer byte.
    localparam int unsigned FRAME_LEN   = 9;
    localparam int unsigned PAYLOAD_W   = 48;
    localparam logic [3:0]  BODY_FIRST  = 4'd2;
    localparam logic [3:0]  FOOTER_IDX  = 4'(FRAME_LEN - 1);

    // Parser phases.
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_WAIT   = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    // One received byte travelling from the input register to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_word;

endpackage

// File: hdl/dhfe_in_reg.sv
module dhfe_in_reg
    import dhfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_ready,
    output t_byte_word o_word
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register frees up whenever the parser takes its word.
    assign o_in_stall = r_valid && !i_ready;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    // Byte capture on acceptance; no reset needed for the data.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.data  = r_byte;

endmodule

// File: hdl/dhfe_parser.sv
module dhfe_parser
    import dhfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_byte_word           i_word,
    output logic                 o_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_frame_kind,
    output logic [PAYLOAD_W-1:0] o_payload
);

    t_phase               r_phase, n_phase;
    logic [3:0]           r_count, n_count;
    logic [1:0]           r_kind, n_kind;
    logic [PAYLOAD_W-1:0] r_store, n_store;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_kind;
    logic [PAYLOAD_W-1:0] r_out_payload;

    logic       fire;
    logic       is_hdr;
    logic       hit;
    logic [7:0] b;
    logic [7:0] kind_ext;
    logic [2:0] slot;

    // The result register can take a word when empty or being emptied.
    assign o_ready  = !r_out_valid || !i_out_stall;
    assign fire     = i_word.valid && o_ready;
    assign b        = i_word.data;
    assign is_hdr   = (b >= HDR_BASE) && (b <= HDR_LAST);
    assign kind_ext = {6'd0, r_kind};
    assign slot     = 3'(r_count - BODY_FIRST);

    // Next state of the frame parser for the byte in the input register.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_kind  = r_kind;
        n_store = r_store;
        hit     = 1'b0;
        if (fire) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (b == HDR_BASE + kind_ext) begin
                        n_count = BODY_FIRST;
                        n_phase = PH_BODY;
                    end else if (is_hdr) begin
                        n_kind = 2'(b - HDR_BASE);
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
                PH_BODY: begin
                    if (r_count >= FOOTER_IDX) begin
                        hit     = (b == FTR_BASE + kind_ext);
                        n_phase = PH_SEARCH;
                        n_count = 4'd0;
                    end else begin
                        if (r_count >= BODY_FIRST) begin
                            n_store[{slot, 3'b000} +: 8] = b;
                        end
                        n_count = r_count + 4'd1;
                    end
                end
                default: begin
                    if (is_hdr) begin
                        n_kind  = 2'(b - HDR_BASE);
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
            endcase
        end
    end

    // Result valid: set by a matching footer, cleared once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = hit;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_count     <= 4'd0;
            r_kind      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload store and result fields.
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        if (hit) begin
            r_out_kind    <= r_kind;
            r_out_payload <= r_store;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out_kind;
    assign o_payload    = r_out_payload;

endmodule

// File: hdl/double_header_frame_extractor_top.sv
// The footer byte passes the input register; the parser then sets the result
// register. Throughput: one byte per cycle while o_in_stall is low; the input
// and result registers let a byte enter while a finished frame waits downstream.
// Reset: synchronous, active low; clears the parser phase, byte count,
// header kind and both valid flags; the payload registers are not reset.
module double_header_frame_extractor_top
    import dhfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_frame_kind,
    output logic [PAYLOAD_W-1:0] o_payload
);

    t_byte_word word;
    logic       ready;

    // Input register.
    dhfe_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_ready    (ready),
        .o_word     (word)
    );

    // Frame parser with the result register.
    dhfe_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (word),
        .o_ready      (ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_kind (o_frame_kind),
        .o_payload    (o_payload)
    );

endmodule

// File: hdl/dhfe_checker.sv
module dhfe_checker
    import dhfe_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [1:0]           o_frame_kind,
    input logic [PAYLOAD_W-1:0] o_payload
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_kind)
            && $stable(o_payload))
        else $error("stalled result word changed");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Only three header kinds exist.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_kind != 2'd3)
        else $error("invalid frame kind");

    // The input side only stalls while a result is held back downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind double_header_frame_extractor_top dhfe_checker u_dhfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_frame_kind (o_frame_kind),
    .o_payload    (o_payload)
);

// File: test/tb.sv
module tb
    import dhfe_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    // One finished frame as the block should report it.
    typedef struct packed {
        logic [1:0]           kind;
        logic [PAYLOAD_W-1:0] data;
    } t_frame;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           frame_kind;
    logic [PAYLOAD_W-1:0] payload;

    // Idling pressure of the current phase, in percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Parser state as the block should hold it.
    t_phase               rx_phase   = PH_SEARCH;
    logic [3:0]           rx_count   = '0;
    logic [1:0]           rx_kind    = '0;
    logic [PAYLOAD_W-1:0] rx_payload = '0;

    t_frame frames_due[$];
    t_frame frame_seen;
    int     words_sent     = 0;
    int     frames_checked = 0;
    int     frames_dropped = 0;
    int     mismatches     = 0;
    int     quiet_cycles   = 0;

    double_header_frame_extractor_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_rx_byte    (rx_byte),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_frame_kind (frame_kind),
        .o_payload    (payload)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Advance the expected parser state by one accepted word.
    task automatic parse_word(input logic [7:0] b);
        t_frame done;
        case (rx_phase)
            PH_WAIT: begin
                if (b == HDR_BASE + 8'(rx_kind)) begin
                    rx_count = BODY_FIRST;
                    rx_phase = PH_BODY;
                end else if (b >= HDR_BASE && b <= HDR_LAST) begin
                    rx_kind = 2'(b - HDR_BASE);
                end else begin
                    rx_phase = PH_SEARCH;
                end
            end
            PH_BODY: begin
                if (rx_count >= FOOTER_IDX) begin
                    if (b == FTR_BASE + 8'(rx_kind)) begin
                        done.kind = rx_kind;
                        done.data = rx_payload;
                        frames_due.push_back(done);
                    end else begin
                        frames_dropped++;
                    end
                    rx_phase = PH_SEARCH;
                    rx_count = '0;
                end else begin
                    if (rx_count >= BODY_FIRST) begin
                        rx_payload[int'(rx_count - BODY_FIRST) * 8 +: 8] = b;
                    end
                    rx_count = rx_count + 4'd1;
                end
            end
            default: begin
                if (b >= HDR_BASE && b <= HDR_LAST) begin
                    rx_kind  = 2'(b - HDR_BASE);
                    rx_phase = PH_WAIT;
                end else begin
                    rx_phase = PH_SEARCH;
                end
            end
        endcase
    endtask

    // Offer one word, possibly after some idle cycles, and wait until it is taken.
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parse_word(b);
        words_sent++;
    endtask

    // Random byte, often one of the marker values or an extreme.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(7))
                0: return HDR_BASE;
                1: return HDR_BASE + 8'd1;
                2: return HDR_LAST;
                3: return FTR_BASE;
                4: return FTR_BASE + 8'd1;
                5: return FTR_BASE + 8'd2;
                6: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    // A whole frame with random body; the footer either matches or not.
    task automatic send_frame(input logic [1:0] kind, input bit footer_ok);
        logic [7:0] footer;
        send_word(HDR_BASE + 8'(kind));
        send_word(HDR_BASE + 8'(kind));
        repeat (6) send_word(pick_byte());
        footer = FTR_BASE + 8'(kind);
        if (!footer_ok) begin
            do footer = pick_byte(); while (footer == FTR_BASE + 8'(kind));
        end
        send_word(footer);
    endtask

    // Accept results at random and compare each with the oldest expected frame.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            if (frames_due.size() == 0) begin
                $display("%0t ns: unexpected frame, expected none, got kind %0d payload %h",
                         $time, frame_kind, payload);
                mismatches++;
            end else begin
                frame_seen = frames_due.pop_front();
                frames_checked++;
                if (frame_kind !== frame_seen.kind) begin
                    $display("%0t ns: frame kind mismatch, expected %0d, got %0d",
                             $time, frame_seen.kind, frame_kind);
                    mismatches++;
                end
                if (payload !== frame_seen.data) begin
                    $display("%0t ns: payload mismatch, expected %h, got %h",
                             $time, frame_seen.data, payload);
                    mismatches++;
                end
            end
        end
    end

    // Give up when no word moves on either side for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // A valid frame of kind 0 with an all-zero body.
    task automatic test_clean_frames();
        send_word(HDR_BASE);
        send_word(HDR_BASE);
        repeat (6) send_word(8'h00);
        send_word(FTR_BASE);
    endtask

    // A new header while waiting restarts the wait; body words that look
    // like headers are taken as data.
    task automatic test_header_restart();
        send_word(HDR_BASE + 8'd1);
        send_word(HDR_LAST);
        send_word(HDR_LAST);
        send_word(8'hFF);
        send_word(HDR_BASE);
        send_word(HDR_BASE + 8'd1);
        send_word(HDR_LAST);
        send_word(8'hFF);
        send_word(8'hFF);
        send_word(FTR_BASE + 8'd2);
    endtask

    // Any other word while waiting for the second header sends the parser
    // back to the search.
    task automatic test_wait_abort();
        send_word(HDR_BASE + 8'd1);
        send_word(8'h00);
    endtask

    // A footer of the wrong kind drops the frame silently.
    task automatic test_footer_mismatch();
        send_word(HDR_BASE + 8'd1);
        send_word(HDR_BASE + 8'd1);
        send_word(8'h12);
        send_word(8'h34);
        send_word(8'h56);
        send_word(8'h78);
        send_word(8'h9A);
        send_word(8'hBC);
        send_word(FTR_BASE);
    endtask

    // Mostly well-formed frames, with dropped frames, restarts, aborts and noise.
    task automatic test_random_traffic(input int n_words, input int idle_pct,
                                       input int stall_pct);
        int         target;
        int         pick;
        logic [1:0] kind;
        logic [7:0] other;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + n_words;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            kind = 2'($urandom_range(2));
            if (pick < 70) begin
                send_frame(kind, 1'b1);
            end else if (pick < 80) begin
                send_frame(kind, 1'b0);
            end else if (pick < 88) begin
                send_word(HDR_BASE + 8'(kind));
                send_frame(2'((kind + $urandom_range(1, 2)) % 3), 1'b1);
            end else if (pick < 94) begin
                send_word(HDR_BASE + 8'(kind));
                do other = pick_byte(); while (other >= HDR_BASE && other <= HDR_LAST);
                send_word(other);
            end else begin
                repeat ($urandom_range(1, 4)) send_word(pick_byte());
            end
        end
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_clean_frames();
        test_header_restart();
        test_wait_abort();
        test_footer_mismatch();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 73, 0);
        test_random_traffic(400, 0, 73);
        test_random_traffic(400, 10, 10);

        // Let every outstanding frame drain, then allow for stray results.
        in_valid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes under four idling patterns; %0d frames checked, %0d dropped.",
                 words_sent, frames_checked, frames_dropped);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
